// ===== hdl/epse_pkg.sv =====
package epse_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PPR        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIST       = 3'd4;

  // reset values of the configuration registers
  localparam logic [31:0] RST_MIN_PERIOD = 32'h0000_0000;
  localparam logic [31:0] RST_MAX_PERIOD = 32'hFFFF_FFFF;
  localparam logic [15:0] RST_PPR        = 16'd20;
  localparam logic [31:0] RST_DIST       = 32'h0001_0000;

  // arithmetic constants
  localparam int K_MILLI   = 1000;
  localparam int K_W       = 10;
  localparam int EMA_OLD   = 7;
  localparam int EMA_NEW   = 3;
  localparam int EMA_DIV   = 10;
  localparam int MIX_W     = 36;
  localparam int QUO_W     = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = 5;

  // divide by ten of the blend: 2^32 = 10 * EMA_HI_Q + EMA_HI_R, and the
  // low part is halved and divided by five through its reciprocal
  localparam logic [31:0] EMA_HI_Q     = 32'd429496729;
  localparam int          EMA_HI_R     = 6;
  localparam logic [31:0] EMA_RECIP    = 32'hCCCC_CCCD;
  localparam int          EMA_RECIP_SH = 34;

  typedef struct packed {
    logic        enable;
    logic [31:0] min_period_us;
    logic [31:0] max_period_us;
    logic [15:0] pulses_per_rev;
    logic [31:0] dist_per_pulse;
  } cfg_t;

  typedef struct packed {
    logic start;      // request accepted, update counters
    logic mul_dist;   // dist_per_pulse * 1000
    logic mul_cnt;    // times accepted count
    logic check;      // saturation test and divider load
    logic div_step;   // one restoring division step
    logic mix;        // blend of old and raw speed
    logic fold;       // split the blend for the divide by ten
    logic recip;      // reciprocal multiply by one fifth
    logic speed_take; // commit new speed
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic calc_pending;
    logic raw_sat;
  } status_t;

endpackage

// ===== hdl/epse_ctrl.sv =====
module epse_ctrl import epse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_CHECK,
    S_DIV_RAW,
    S_MIX,
    S_FOLD,
    S_RECIP,
    S_UPDATE,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic                last_step;

  assign last_step   = (step_q == STEP_W'(DIV_STEPS - 1));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.mul_dist = 1'b1;
        state_d        = status_i.calc_pending ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd_o.mul_cnt = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        step_d      = '0;
        state_d     = status_i.raw_sat ? S_MIX : S_DIV_RAW;
      end
      S_DIV_RAW: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (last_step) begin
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = S_RECIP;
      end
      S_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.speed_take = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/epse_dp.sv =====
module epse_dp import epse_pkg::*; #(
  parameter int PERIOD_BITS = 32,
  parameter int PPR_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [31:0] period_us_i,
  input  logic        healthy_i,
  output logic [31:0] speed_o,
  output logic        updated_o,
  output logic [31:0] total_pulses_o,
  output logic [31:0] healthy_pulses_o,
  output logic [31:0] revolutions_o
);

  localparam int SUM_W   = PERIOD_BITS + PPR_BITS;
  localparam int PROD1_W = 32 + K_W;
  localparam int NUM_W   = PROD1_W + PPR_BITS;
  localparam int HI_W    = NUM_W - QUO_W;
  localparam int CMP_W   = (HI_W > SUM_W) ? HI_W : SUM_W;
  localparam int REM_W   = SUM_W + 1;
  localparam int MHI_W   = MIX_W - QUO_W;
  localparam int FOLD_W  = QUO_W + 1;
  localparam int RPROD_W = 2 * QUO_W;

  // state of the estimator
  logic [PPR_BITS-1:0] rev_cnt_q, acc_q;
  logic [SUM_W-1:0]    sum_q;
  logic [31:0]         speed_q, total_q, healthy_q, revs_q;
  logic                upd_q, calc_q, sat_q;

  // working registers of the speed calculation
  logic [SUM_W-1:0]    snap_sum_q, rem_q, divisor_q;
  logic [PPR_BITS-1:0] snap_cnt_q;
  logic [PROD1_W-1:0]  prod1_q;
  logic [NUM_W-1:0]    num_q;
  logic [QUO_W-1:0]    quo_q;
  logic [MIX_W-1:0]    mix_q;
  logic [QUO_W-1:0]    fold_q, hi_part_q;
  logic [RPROD_W-1:0]  recip_q;

  logic [31:0]         period_ext;
  logic                in_win, boundary;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat, sum_take;
  logic [PPR_BITS-1:0] acc_inc, acc_take;
  logic [15:0]         ppr_m1;
  logic [HI_W-1:0]     num_hi;
  logic                raw_sat;
  logic [QUO_W-1:0]    raw_sel;
  logic [MIX_W-1:0]    mix;
  logic [MHI_W-1:0]    mix_hi;
  logic [FOLD_W-1:0]   fold_sum;
  logic [REM_W-1:0]    rem_sh, rem_sub;
  logic                ge;

  assign period_ext = 32'(period_us_i[PERIOD_BITS-1:0]);
  assign in_win     = healthy_i && (period_ext > cfg_i.min_period_us)
                      && (period_ext < cfg_i.max_period_us);
  assign sum_add    = {1'b0, sum_q} + REM_W'(period_us_i[PERIOD_BITS-1:0]);
  assign sum_sat    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign sum_take   = in_win ? sum_sat : sum_q;
  assign acc_inc    = (acc_q == '1) ? acc_q : acc_q + PPR_BITS'(1);
  assign acc_take   = in_win ? acc_inc : acc_q;
  assign ppr_m1     = cfg_i.pulses_per_rev - 16'd1;
  assign boundary   = (rev_cnt_q == ppr_m1[PPR_BITS-1:0]);

  // quotient overflows 32 bits exactly when the upper part reaches the divisor
  assign num_hi  = num_q[NUM_W-1:QUO_W];
  assign raw_sat = (CMP_W'(num_hi) >= CMP_W'(snap_sum_q));

  assign raw_sel = sat_q ? '1 : quo_q;
  assign mix     = MIX_W'(speed_q) * MIX_W'(EMA_OLD) + MIX_W'(raw_sel) * MIX_W'(EMA_NEW);

  // blend below ten times 2^32: fold the upper bits into the lower word
  assign mix_hi   = mix_q[MIX_W-1:QUO_W];
  assign fold_sum = FOLD_W'(mix_q[QUO_W-1:0]) + FOLD_W'(mix_hi) * FOLD_W'(EMA_HI_R);

  // restoring division, one quotient bit per step
  assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor_q});
  assign rem_sub = rem_sh - {1'b0, divisor_q};

  assign status_o.calc_pending = calc_q;
  assign status_o.raw_sat      = raw_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_cnt_q <= '0;
      acc_q     <= '0;
      sum_q     <= '0;
      speed_q   <= '0;
      total_q   <= '0;
      healthy_q <= '0;
      revs_q    <= '0;
      upd_q     <= 1'b0;
      calc_q    <= 1'b0;
      sat_q     <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        upd_q  <= 1'b0;
        calc_q <= 1'b0;
        if (cfg_i.enable) begin
          total_q <= total_q + 32'd1;
          if (in_win) begin
            healthy_q <= healthy_q + 32'd1;
          end
          if (boundary) begin
            revs_q    <= revs_q + 32'd1;
            rev_cnt_q <= '0;
            sum_q     <= '0;
            acc_q     <= '0;
            calc_q    <= (sum_take != '0) && (acc_take != '0);
          end else begin
            rev_cnt_q <= rev_cnt_q + PPR_BITS'(1);
            sum_q     <= sum_take;
            acc_q     <= acc_take;
          end
        end
      end
      if (cmd_i.check) begin
        sat_q <= raw_sat;
      end
      if (cmd_i.speed_take) begin
        speed_q <= hi_part_q + QUO_W'(recip_q[RPROD_W-1:EMA_RECIP_SH]);
        upd_q   <= 1'b1;
      end
    end
  end

  // datapath payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      snap_sum_q <= sum_take;
      snap_cnt_q <= acc_take;
    end
    if (cmd_i.mul_dist) begin
      prod1_q <= PROD1_W'(cfg_i.dist_per_pulse) * PROD1_W'(K_MILLI);
    end
    if (cmd_i.mul_cnt) begin
      num_q <= NUM_W'(prod1_q) * NUM_W'(snap_cnt_q);
    end
    if (cmd_i.check) begin
      rem_q     <= SUM_W'(num_hi);
      quo_q     <= num_q[QUO_W-1:0];
      divisor_q <= snap_sum_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
    if (cmd_i.mix) begin
      mix_q <= mix;
    end
    if (cmd_i.fold) begin
      fold_q    <= fold_sum[FOLD_W-1:1];
      hi_part_q <= QUO_W'(mix_hi) * EMA_HI_Q;
    end
    if (cmd_i.recip) begin
      recip_q <= RPROD_W'(fold_q) * RPROD_W'(EMA_RECIP);
    end
    if (cmd_i.out_load) begin
      speed_o          <= speed_q;
      updated_o        <= upd_q;
      total_pulses_o   <= total_q;
      healthy_pulses_o <= healthy_q;
      revolutions_o    <= revs_q;
    end
  end

endmodule

// ===== hdl/encoder_period_speed_estimator_core.sv =====
// encoder period speed estimator
// input channel (in_valid_i/in_ready_o) takes one pulse request: its period in
// microseconds and a health flag. every request gives exactly one result on the
// output channel (out_valid_o/out_ready_i): smoothed speed, an updated flag and
// the pulse, in-window and revolution counters after that pulse.
// configuration port (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is
// always ready; write it only while no request is in flight.
// sequence: a pulse with no fresh estimate goes from acceptance through the
// evaluation step to the hand-over. a revolution pulse with a fresh estimate
// runs the distance and count multiplies, a saturation check, 32 steps of the
// restoring divider for the raw speed, a blend and the divide by ten (fold,
// reciprocal multiply, commit), then the hand-over. a saturated raw speed
// skips the divider.
// requests: one at a time; in_ready_o rises with the result, so a new request
// is taken only once the last one is handed over. a stalled receiver holds
// the sequencer at the hand-over while a result waits, so the next request
// waits as well.
// reset clears the counters, accumulators and speed, empties the output
// register and loads the configuration defaults (disabled, window open, 20
// pulses per revolution, 1.0 mm per pulse).
module encoder_period_speed_estimator_core import epse_pkg::*; #(
  parameter int PERIOD_BITS = 32,
  parameter int PPR_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          period_us_i,
  input  logic                 healthy_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          speed_o,
  output logic                 updated_o,
  output logic [31:0]          total_pulses_o,
  output logic [31:0]          healthy_pulses_o,
  output logic [31:0]          revolutions_o
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    cfg_write;
  logic    in_accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && in_ready_o;

  // configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.min_period_us  <= RST_MIN_PERIOD;
      cfg_q.max_period_us  <= RST_MAX_PERIOD;
      cfg_q.pulses_per_rev <= RST_PPR;
      cfg_q.dist_per_pulse <= RST_DIST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        REG_ENABLE:     cfg_q.enable         <= cfg_data_i[0];
        REG_MIN_PERIOD: cfg_q.min_period_us  <= cfg_data_i;
        REG_MAX_PERIOD: cfg_q.max_period_us  <= cfg_data_i;
        REG_PPR:        cfg_q.pulses_per_rev <= cfg_data_i[15:0];
        REG_DIST:       cfg_q.dist_per_pulse <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer: accept, multiply, divide, blend, hand over
  epse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, accumulators, multipliers, divider and result register
  epse_dp #(
    .PERIOD_BITS(PERIOD_BITS),
    .PPR_BITS   (PPR_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .period_us_i     (period_us_i),
    .healthy_i       (healthy_i),
    .speed_o         (speed_o),
    .updated_o       (updated_o),
    .total_pulses_o  (total_pulses_o),
    .healthy_pulses_o(healthy_pulses_o),
    .revolutions_o   (revolutions_o)
  );

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("request accepted while previous one still in flight");

  // the result register is never overwritten while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  // loading the result register always presents it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // the datapath starts on exactly the accepted requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start == in_accept)
    else $error("datapath start out of step with the input handshake");

endmodule
